>>> rtl/core/rbsi_pkg.sv
// ----------------------------------------------------------------------------
// rbsi_pkg: shared types and constants of the ray versus box slab test
// Holds the distance format, the clamp values and the register indexes.
// ----------------------------------------------------------------------------
package rbsi_pkg;

    // Slab distances are carried at 64 bits while they are compared.
    localparam int T_W = 64;
    localparam logic signed [T_W-1:0] T_CAP = 64'sh4000_0000_0000_0000;
    localparam logic signed [T_W-1:0] T_INF = 64'sh4000_0000_0000_0001;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_Z = 3'd5;

    // Entry and exit of one axis; ok is low when the axis alone rules out a hit.
    typedef struct packed {
        logic                    ok;
        logic signed [T_W-1:0]   enter;
        logic signed [T_W-1:0]   leave;
    } slab_t;

endpackage

>>> rtl/core/rbsi_div.sv
// ----------------------------------------------------------------------------
// rbsi_div: pipelined unsigned restoring divider
// Computes (dividend * 2^FB) / divisor, one quotient bit per register stage,
// with a tag carried alongside each request.
// ----------------------------------------------------------------------------
module rbsi_div #(
    parameter int CB    = 32,
    parameter int FB    = 16,
    parameter int TAG_W = 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  logic [CB-1:0]       dividend,
    input  logic [CB-1:0]       divisor,
    input  logic [TAG_W-1:0]    in_tag,
    output logic                out_valid,
    output logic [CB+FB-1:0]    quotient,
    output logic [TAG_W-1:0]    out_tag
);
    localparam int N = CB + FB;

    logic             v_reg   [0:N];
    logic [CB-1:0]    rem_reg [0:N];
    logic [N-1:0]     num_reg [0:N];
    logic [N-1:0]     q_reg   [0:N];
    logic [CB-1:0]    dsr_reg [0:N];
    logic [TAG_W-1:0] tag_reg [0:N];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= '0;
            num_reg[0] <= {dividend, {FB{1'b0}}};
            q_reg[0]   <= '0;
            dsr_reg[0] <= divisor;
            tag_reg[0] <= in_tag;
        end
    end

    for (genvar s = 0; s < N; s++)
    begin : g_stage
        logic [CB:0]   trial;
        logic          ge;
        logic [CB:0]   diff;
        logic [CB-1:0] rem_next;

        assign trial    = {rem_reg[s], num_reg[s][N-1]};
        assign ge       = trial >= {1'b0, dsr_reg[s]};
        assign diff     = trial - {1'b0, dsr_reg[s]};
        // After a subtraction the remainder is below the divisor, so CB bits hold it.
        assign rem_next = ge ? diff[CB-1:0] : trial[CB-1:0];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[s+1] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[s+1] <= v_reg[s];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s+1] <= rem_next;
                num_reg[s+1] <= {num_reg[s][N-2:0], 1'b0};
                q_reg[s+1]   <= {q_reg[s][N-2:0], ge};
                dsr_reg[s+1] <= dsr_reg[s];
                tag_reg[s+1] <= tag_reg[s];
            end
        end
    end

    assign out_valid = v_reg[N];
    assign quotient  = q_reg[N];
    assign out_tag   = tag_reg[N];

endmodule

>>> rtl/core/rbsi_axis.sv
// ----------------------------------------------------------------------------
// rbsi_axis: slab entry and exit distances of one axis
// Forms the bound differences, divides both by the direction component and
// orders the pair by the sign of the direction.
// ----------------------------------------------------------------------------
module rbsi_axis #(
    parameter int CB = 32,
    parameter int FB = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic signed [CB-1:0]  lo,
    input  logic signed [CB-1:0]  hi,
    input  logic signed [CB-1:0]  org,
    input  logic signed [CB-1:0]  dir,
    output logic                  out_valid,
    output rbsi_pkg::slab_t       slab
);
    import rbsi_pkg::*;

    localparam int N  = CB + FB;
    localparam int QX = (N > 63) ? N : 63;

    logic                 vp_reg;
    logic signed [CB:0]   num_lo_reg;
    logic signed [CB:0]   num_hi_reg;
    logic signed [CB-1:0] dir_reg;
    logic                 inside_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vp_reg <= 1'b0;
        end
        else if (en)
        begin
            vp_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_lo_reg <= {lo[CB-1], lo} - {org[CB-1], org};
            num_hi_reg <= {hi[CB-1], hi} - {org[CB-1], org};
            dir_reg    <= dir;
            inside_reg <= (org >= lo) && (org <= hi);
        end
    end

    logic [CB:0]   abs_lo;
    logic [CB:0]   abs_hi;
    logic [CB-1:0] abs_dir;
    logic          dneg;
    logic          dzero;
    logic          neg_lo;
    logic          neg_hi;

    always_comb
    begin
        abs_lo  = num_lo_reg[CB] ? (CB+1)'(-num_lo_reg) : num_lo_reg;
        abs_hi  = num_hi_reg[CB] ? (CB+1)'(-num_hi_reg) : num_hi_reg;
        abs_dir = dir_reg[CB-1] ? CB'(-dir_reg) : dir_reg;
        dneg    = dir_reg[CB-1];
        dzero   = (dir_reg == '0);
        neg_lo  = num_lo_reg[CB] != dneg;
        neg_hi  = num_hi_reg[CB] != dneg;
    end

    logic          lo_valid;
    logic          hi_valid;
    logic [N-1:0]  q_lo;
    logic [N-1:0]  q_hi;
    logic [3:0]    tag_lo;
    logic [0:0]    tag_hi;

    rbsi_div #(.CB(CB), .FB(FB), .TAG_W(4)) u_div_lo (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (vp_reg),
        .dividend  (abs_lo[CB-1:0]),
        .divisor   (abs_dir),
        .in_tag    ({neg_lo, dneg, dzero, inside_reg}),
        .out_valid (lo_valid),
        .quotient  (q_lo),
        .out_tag   (tag_lo)
    );

    rbsi_div #(.CB(CB), .FB(FB), .TAG_W(1)) u_div_hi (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (vp_reg),
        .dividend  (abs_hi[CB-1:0]),
        .divisor   (abs_dir),
        .in_tag    (neg_hi),
        .out_valid (hi_valid),
        .quotient  (q_hi),
        .out_tag   (tag_hi)
    );

    logic [QX-1:0]          qx_lo;
    logic [QX-1:0]          qx_hi;
    logic [62:0]            qc_lo;
    logic [62:0]            qc_hi;
    logic signed [T_W-1:0]  t_lo;
    logic signed [T_W-1:0]  t_hi;
    slab_t                  slab_next;
    slab_t                  slab_reg;
    logic                   vo_reg;

    always_comb
    begin
        qx_lo = QX'(q_lo);
        qx_hi = QX'(q_hi);
        // Quotient magnitude is clamped to 2^62.
        qc_lo = (qx_lo > QX'(T_CAP)) ? 63'(T_CAP) : qx_lo[62:0];
        qc_hi = (qx_hi > QX'(T_CAP)) ? 63'(T_CAP) : qx_hi[62:0];
        t_lo  = tag_lo[3] ? -$signed({1'b0, qc_lo}) : $signed({1'b0, qc_lo});
        t_hi  = tag_hi[0] ? -$signed({1'b0, qc_hi}) : $signed({1'b0, qc_hi});
        if (tag_lo[1])
        begin
            slab_next.ok    = tag_lo[0];
            slab_next.enter = -T_INF;
            slab_next.leave = T_INF;
        end
        else
        begin
            slab_next.ok    = 1'b1;
            slab_next.enter = tag_lo[2] ? t_hi : t_lo;
            slab_next.leave = tag_lo[2] ? t_lo : t_hi;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vo_reg <= 1'b0;
        end
        else if (en)
        begin
            vo_reg <= lo_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            slab_reg <= slab_next;
        end
    end

    assign out_valid = vo_reg;
    assign slab      = slab_reg;

    assert property (@(posedge clk) disable iff (!rst_n) lo_valid == hi_valid)
        else $error("axis dividers out of step");

endmodule

>>> rtl/core/ray_box_slab_intersect_top.sv
// ----------------------------------------------------------------------------
// ray_box_slab_intersect_top: ray versus axis-aligned box, slab method
// Tests one ray per cycle, while not stalled, against the box held in six registers and reports
// hit and entry distance.
// ----------------------------------------------------------------------------
// The block accepts one ray request every cycle while in_stall is low and
// returns one result per ray, in order, in the default Q16.16 format. The
// pipeline runs through six restoring dividers, which produce one quotient
// bit per pipeline stage. A stall on the result side while a result waits
// freezes the whole pipeline; nothing is dropped or repeated. Box registers
// should be written only while no ray is in flight.
module ray_box_slab_intersect_top #(
    parameter int COORD_BITS = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [rbsi_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [COORD_BITS-1:0]         cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [COORD_BITS-1:0]  origin_x,
    input  logic signed [COORD_BITS-1:0]  origin_y,
    input  logic signed [COORD_BITS-1:0]  origin_z,
    input  logic signed [COORD_BITS-1:0]  dir_x,
    input  logic signed [COORD_BITS-1:0]  dir_y,
    input  logic signed [COORD_BITS-1:0]  dir_z,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          hit,
    output logic signed [COORD_BITS-1:0]  t_entry
);
    import rbsi_pkg::*;

    localparam logic signed [T_W-1:0] TMAX = (64'sd1 <<< (COORD_BITS - 1)) - 64'sd1;

    logic signed [COORD_BITS-1:0] min_x_reg, min_y_reg, min_z_reg;
    logic signed [COORD_BITS-1:0] max_x_reg, max_y_reg, max_z_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_x_reg <= '0;
            min_y_reg <= '0;
            min_z_reg <= '0;
            max_x_reg <= '0;
            max_y_reg <= '0;
            max_z_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MIN_X: min_x_reg <= cfg_data;
                REG_MIN_Y: min_y_reg <= cfg_data;
                REG_MIN_Z: min_z_reg <= cfg_data;
                REG_MAX_X: max_x_reg <= cfg_data;
                REG_MAX_Y: max_y_reg <= cfg_data;
                REG_MAX_Z: max_z_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    logic en;
    logic out_valid_reg;

    assign en       = !out_valid_reg || !out_stall;
    assign in_stall = !en;

    logic  vx, vy, vz;
    slab_t sx, sy, sz;

    rbsi_axis #(.CB(COORD_BITS), .FB(FRAC_BITS)) u_axis_x (
        .clk (clk), .rst_n (rst_n), .en (en), .in_valid (in_valid),
        .lo (min_x_reg), .hi (max_x_reg), .org (origin_x), .dir (dir_x),
        .out_valid (vx), .slab (sx)
    );

    rbsi_axis #(.CB(COORD_BITS), .FB(FRAC_BITS)) u_axis_y (
        .clk (clk), .rst_n (rst_n), .en (en), .in_valid (in_valid),
        .lo (min_y_reg), .hi (max_y_reg), .org (origin_y), .dir (dir_y),
        .out_valid (vy), .slab (sy)
    );

    rbsi_axis #(.CB(COORD_BITS), .FB(FRAC_BITS)) u_axis_z (
        .clk (clk), .rst_n (rst_n), .en (en), .in_valid (in_valid),
        .lo (min_z_reg), .hi (max_z_reg), .org (origin_z), .dir (dir_z),
        .out_valid (vz), .slab (sz)
    );

    // Largest entry and smallest exit over the three axes.
    logic                  vr_reg;
    logic                  ok_reg;
    logic signed [T_W-1:0] best_in_reg;
    logic signed [T_W-1:0] best_out_reg;
    logic signed [T_W-1:0] in_xy, out_xy;

    always_comb
    begin
        in_xy  = (sy.enter > sx.enter) ? sy.enter : sx.enter;
        out_xy = (sy.leave < sx.leave) ? sy.leave : sx.leave;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vr_reg <= 1'b0;
        end
        else if (en)
        begin
            vr_reg <= vx;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ok_reg       <= sx.ok && sy.ok && sz.ok;
            best_in_reg  <= (sz.enter > in_xy) ? sz.enter : in_xy;
            best_out_reg <= (sz.leave < out_xy) ? sz.leave : out_xy;
        end
    end

    logic                         miss;
    logic                         hit_next;
    logic signed [COORD_BITS-1:0] t_next;
    logic                         hit_reg;
    logic signed [COORD_BITS-1:0] t_reg;

    always_comb
    begin
        miss     = !ok_reg || best_in_reg < 0 || best_out_reg < 0
                   || best_in_reg > best_out_reg;
        hit_next = !miss;
        if (miss)
        begin
            t_next = '0;
        end
        else if (best_in_reg > TMAX)
        begin
            t_next = TMAX[COORD_BITS-1:0];
        end
        else
        begin
            t_next = best_in_reg[COORD_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= vr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hit_reg <= hit_next;
            t_reg   <= t_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign hit       = hit_reg;
    assign t_entry   = t_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without a held result");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !hit) |-> (t_entry == '0))
        else $error("miss with nonzero entry distance");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && hit) |-> !t_entry[COORD_BITS-1])
        else $error("hit with negative entry distance");

    assert property (@(posedge clk) disable iff (!rst_n)
        (vx == vy) && (vy == vz))
        else $error("axis pipelines out of step");

endmodule

>>> tb/sv/tb_ray_box_slab_intersect_top.sv
// ----------------------------------------------------------------------------
// tb_ray_box_slab_intersect_top: testbench of the ray versus box slab test
// Writes several boxes through the register port and streams directed and
// random rays under random stalls on both sides and a long stall on the result side. Each result is
// compared with a local slab model, in order.
// ----------------------------------------------------------------------------
module tb_ray_box_slab_intersect_top;
    timeunit 1ns;
    timeprecision 1ps;
    import rbsi_pkg::*;

    localparam int CW = 32;
    localparam int FW = 16;
    localparam logic signed [CW-1:0] ONE = 32'sh0001_0000;
    localparam logic signed [CW-1:0] CMIN = 32'sh8000_0000;
    localparam logic signed [CW-1:0] CMAX = 32'sh7fff_ffff;

    typedef struct {
        logic signed [CW-1:0] org [3];
        logic signed [CW-1:0] dir [3];
    } ray_t;

    typedef struct {
        logic          hit;
        logic [CW-1:0] t;
    } ray_hit_t;

    class ray_hit_book;
        longint   box_lo [3];
        longint   box_hi [3];
        ray_hit_t expected_hits [$];
        int       errors;

        function new();
            for (int a = 0; a < 3; a++)
            begin
                box_lo[a] = 0;
                box_hi[a] = 0;
            end
            errors = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic signed [CW-1:0] v);
            case (idx)
                REG_MIN_X: box_lo[0] = v;
                REG_MIN_Y: box_lo[1] = v;
                REG_MIN_Z: box_lo[2] = v;
                REG_MAX_X: box_hi[0] = v;
                REG_MAX_Y: box_hi[1] = v;
                REG_MAX_Z: box_hi[2] = v;
                default: ;
            endcase
        endfunction

        // Restoring division, one quotient bit per step, magnitude clamped.
        function longint slab_distance(longint num, longint den);
            bit neg;
            bit sat;
            longint unsigned un, ud, r, q, b;
            neg = (num < 0) != (den < 0);
            un = num < 0 ? -num : num;
            ud = den < 0 ? -den : den;
            r = 0;
            q = 0;
            sat = 0;
            for (int i = CW + FW; i >= 0; i--)
            begin
                b = (i >= FW) ? ((un >> (i - FW)) & 1) : 0;
                r = (r << 1) | b;
                if (q > (longint'(T_CAP) >> 1))
                    sat = 1;
                if (!sat)
                    q = q << 1;
                if (r >= ud)
                begin
                    r = r - ud;
                    if (!sat)
                        q = q | 1;
                end
            end
            if (sat || q > longint'(T_CAP))
                q = longint'(T_CAP);
            return neg ? -longint'(q) : longint'(q);
        endfunction

        function void note_request(ray_t ray);
            longint   best_in, best_out, o, d, t0, t1, s;
            bit       ok;
            ray_hit_t e;
            best_in = -longint'(T_INF);
            best_out = longint'(T_INF);
            ok = 1;
            for (int a = 0; a < 3; a++)
            begin
                o = ray.org[a];
                d = ray.dir[a];
                if (d == 0)
                begin
                    if (o < box_lo[a] || o > box_hi[a])
                        ok = 0;
                end
                else
                begin
                    t0 = slab_distance(box_lo[a] - o, d);
                    t1 = slab_distance(box_hi[a] - o, d);
                    if (d < 0)
                    begin
                        s = t0;
                        t0 = t1;
                        t1 = s;
                    end
                    if (t0 > best_in)
                        best_in = t0;
                    if (t1 < best_out)
                        best_out = t1;
                end
            end
            if (!ok || best_in < 0 || best_out < 0 || best_in > best_out)
            begin
                e.hit = 0;
                e.t = '0;
            end
            else
            begin
                e.hit = 1;
                e.t = (best_in > longint'(CMAX)) ? CMAX : best_in[CW-1:0];
            end
            expected_hits.push_back(e);
        endfunction

        function void check(logic hit, logic [CW-1:0] t);
            ray_hit_t e;
            if (expected_hits.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: unexpected result hit=%0b t_entry=%h", hit, t);
                return;
            end
            e = expected_hits.pop_front();
            if (hit !== e.hit || t !== e.t)
            begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: expected hit=%0b t_entry=%h, got hit=%0b t_entry=%h",
                             e.hit, e.t, hit, t);
            end
        endfunction
    endclass

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_we;
    logic [CFG_IDX_W-1:0]       cfg_index;
    logic [CW-1:0]              cfg_data;
    logic                       in_valid;
    logic                       in_stall;
    logic signed [CW-1:0]       origin_x, origin_y, origin_z;
    logic signed [CW-1:0]       dir_x, dir_y, dir_z;
    logic                       out_valid;
    logic                       out_stall;
    logic                       hit;
    logic signed [CW-1:0]       t_entry;

    ray_hit_book book;
    int          tx_idle_pct;
    int          rx_idle_pct;
    int          hold_ask;
    int          hold_left;
    longint      cur_lo [3];
    longint      cur_hi [3];

    ray_box_slab_intersect_top #(.COORD_BITS(CW), .FRAC_BITS(FW)) dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .origin_x(origin_x), .origin_y(origin_y), .origin_z(origin_z),
        .dir_x(dir_x), .dir_y(dir_y), .dir_z(dir_z),
        .out_valid(out_valid), .out_stall(out_stall),
        .hit(hit), .t_entry(t_entry)
    );

    always #5 clk = ~clk;

    // Result side: check accepted results, then choose the next stall.
    always @(posedge clk)
    begin
        if (out_valid && !out_stall)
            book.check(hit, t_entry);
        if (hold_ask > 0)
        begin
            hold_left = hold_ask;
            hold_ask = 0;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < rx_idle_pct);
    end

    initial
    begin
        #5ms;
        $display("tb_ray_box_slab_intersect_top: FAIL");
        $finish;
    end

    task automatic send_ray(ray_t ray);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        origin_x <= ray.org[0];
        origin_y <= ray.org[1];
        origin_z <= ray.org[2];
        dir_x <= ray.dir[0];
        dir_y <= ray.dir[1];
        dir_z <= ray.dir[2];
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        book.note_request(ray);
    endtask

    // Waits until every request has its result, then lets the pipe empty.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (book.expected_hits.size() != 0)
            @(posedge clk);
        repeat (CW + FW + 10) @(posedge clk);
    endtask

    task automatic load_box(longint lo [3], longint hi [3]);
        logic [CW-1:0] v;
        for (int i = 0; i < 8; i++)
        begin
            if (i < 3)
                v = lo[i][CW-1:0];
            else if (i < 6)
                v = hi[i - 3][CW-1:0];
            else
                v = $urandom;
            cfg_we <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_data <= v;
            book.set_reg(CFG_IDX_W'(i), v);
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        for (int a = 0; a < 3; a++)
        begin
            cur_lo[a] = lo[a];
            cur_hi[a] = hi[a];
        end
    endtask

    function automatic ray_t make_ray(logic signed [CW-1:0] ox, logic signed [CW-1:0] oy,
                                      logic signed [CW-1:0] oz, logic signed [CW-1:0] dx,
                                      logic signed [CW-1:0] dy, logic signed [CW-1:0] dz);
        ray_t r;
        r.org[0] = ox;
        r.org[1] = oy;
        r.org[2] = oz;
        r.dir[0] = dx;
        r.dir[1] = dy;
        r.dir[2] = dz;
        return r;
    endfunction

    // Mostly rays aimed at a point of the box, some noise over the full range, some short rays near the origin.
    function automatic ray_t random_ray();
        ray_t   r;
        longint span, target, off;
        int     kind;
        kind = $urandom_range(99);
        for (int a = 0; a < 3; a++)
        begin
            if (kind < 65)
            begin
                span = cur_hi[a] - cur_lo[a];
                if (span < 0)
                    span = -span;
                target = cur_lo[a] + ($urandom % (span + 1));
                off = $signed($urandom_range(8, 0) * (span + ONE)) - 4 * (span + ONE);
                r.org[a] = CW'(target + off);
                r.dir[a] = ($urandom_range(9) == 0) ? '0
                                                    : CW'((-off) >>> $urandom_range(6));
            end
            else if (kind < 85)
            begin
                r.org[a] = $urandom;
                r.dir[a] = $urandom;
            end
            else
            begin
                r.org[a] = $signed($urandom_range(16 * ONE)) - 8 * ONE;
                r.dir[a] = ($urandom_range(3) == 0) ? 0 : $signed($urandom_range(4 * ONE)) - 2 * ONE;
            end
        end
        return r;
    endfunction

    initial
    begin
        longint lo [3];
        longint hi [3];
        ray_t   dr [$];

        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        origin_x = '0;
        origin_y = '0;
        origin_z = '0;
        dir_x = '0;
        dir_y = '0;
        dir_z = '0;
        out_stall = 1'b0;
        hold_ask = 0;
        hold_left = 0;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        book = new();
        for (int a = 0; a < 3; a++)
        begin
            cur_lo[a] = 0;
            cur_hi[a] = 0;
        end
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rays against the unit box around the origin.
        for (int a = 0; a < 3; a++)
        begin
            lo[a] = -ONE;
            hi[a] = ONE;
        end
        load_box(lo, hi);
        dr.push_back(make_ray(-4 * ONE, 0, 0, ONE, 0, 0));
        dr.push_back(make_ray(4 * ONE, ONE / 2, -ONE / 2, -ONE, 0, 0));
        dr.push_back(make_ray(0, 0, 0, ONE, ONE, ONE));
        dr.push_back(make_ray(-3 * ONE, -3 * ONE, -3 * ONE, ONE, ONE, ONE));
        dr.push_back(make_ray(-3 * ONE, 0, 0, 0, 0, 0));
        dr.push_back(make_ray(0, 0, 0, 0, 0, 0));
        dr.push_back(make_ray(-3 * ONE, 2 * ONE, 0, ONE, 0, 0));
        dr.push_back(make_ray(-3 * ONE, 0, 0, -ONE, 0, 0));
        dr.push_back(make_ray(CMIN, 0, 0, 1, 0, 0));
        dr.push_back(make_ray(CMAX, 0, 0, CMIN, 0, 0));
        dr.push_back(make_ray(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX));
        dr.push_back(make_ray(CMAX, CMAX, CMAX, -1, -1, -1));
        dr.push_back(make_ray(-2 * ONE, ONE, -ONE, ONE, 0, 0));
        dr.push_back(make_ray(-ONE, 0, 0, ONE, 0, 0));
        dr.push_back(make_ray(-2 * ONE, -2 * ONE, 0, ONE, ONE / 4, 0));
        foreach (dr[i])
            send_ray(dr[i]);
        drain();

        // Inverted box on x, and the all-zero box.
        lo[0] = ONE;
        hi[0] = -ONE;
        load_box(lo, hi);
        send_ray(make_ray(-4 * ONE, 0, 0, ONE, 0, 0));
        send_ray(make_ray(4 * ONE, 0, 0, -ONE, 0, 0));
        send_ray(make_ray(0, 0, 0, 0, ONE, 0));
        drain();
        for (int a = 0; a < 3; a++)
        begin
            lo[a] = 0;
            hi[a] = 0;
        end
        load_box(lo, hi);
        send_ray(make_ray(-ONE, 0, 0, ONE, 0, 0));
        send_ray(make_ray(-ONE, -ONE, -ONE, ONE, ONE, ONE));
        drain();

        for (int ph = 0; ph < 3; ph++)
        begin
            tx_idle_pct = (ph == 0) ? 7 : (ph == 1) ? 63 : 0;
            rx_idle_pct = (ph == 0) ? 63 : (ph == 1) ? 7 : 0;
            for (int b = 0; b < 4; b++)
            begin
                for (int a = 0; a < 3; a++)
                begin
                    case (b)
                        0:
                        begin
                            lo[a] = $signed($urandom_range(1 << 21)) - (1 << 20);
                            hi[a] = lo[a] + $urandom_range(1 << 20);
                        end
                        1:
                        begin
                            lo[a] = CMIN;
                            hi[a] = CMAX;
                        end
                        2:
                        begin
                            lo[a] = $signed($urandom_range(1 << 20));
                            hi[a] = ($urandom_range(1) == 0) ? lo[a] - $urandom_range(1 << 18)
                                                             : lo[a] + $urandom_range(1 << 18);
                        end
                        default:
                        begin
                            lo[a] = $signed($urandom);
                            hi[a] = $signed($urandom);
                        end
                    endcase
                end
                load_box(lo, hi);
                for (int n = 0; n < 100; n++)
                begin
                    // A long hold on the result side fills the pipe.
                    if (b == 0 && n == 20)
                        hold_ask = 150;
                    send_ray(random_ray());
                end
                drain();
            end
        end

        if (book.errors == 0 && book.expected_hits.size() == 0)
            $display("tb_ray_box_slab_intersect_top: PASS");
        else
            $display("tb_ray_box_slab_intersect_top: FAIL");
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/rbsi_pkg.sv
rtl/core/rbsi_div.sv
rtl/core/rbsi_axis.sv
rtl/core/ray_box_slab_intersect_top.sv
tb/sv/tb_ray_box_slab_intersect_top.sv
